// ----- hw/rtl/iee_pkg.sv -----
// Shared constants, types and helper functions of the infix expression evaluator.
package iee_pkg;

  // Sizes
  localparam int LINE_CHARS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_VARS   = 26;
  localparam int VAL_W      = 32;
  localparam int SYM_W      = 8;
  localparam int VAR_W      = 5;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int PTR_W      = $clog2(LINE_CHARS);
  localparam int CNT_W      = $clog2(LINE_CHARS + 1);
  localparam int DIV_W      = VAL_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  // Word layouts
  localparam int IDX_LSB     = SYM_W;
  localparam int WVAL_LSB    = SYM_W + VAR_W;
  localparam int IN_RAW_W    = SYM_W + VAR_W + VAL_W;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = VAR_W + VAL_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Item kinds
  localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_DIV0      = 2'd1;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

  // Characters
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_LP    = 8'h28;
  localparam logic [SYM_W-1:0] CH_RP    = 8'h29;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [SYM_W-1:0] CH_A     = 8'h41;
  localparam logic [SYM_W-1:0] CH_Z     = 8'h5A;

  localparam logic signed [2*VAL_W-1:0] WIDE_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
  localparam logic signed [2*VAL_W-1:0] WIDE_MIN = -(64'sd1 <<< (VAL_W - 1));

  typedef logic signed [VAL_W-1:0] val_t;

  // Controller to datapath commands, at most one per cycle
  typedef struct packed {
    logic load_item;
    logic do_direct;
    logic do_read;
    logic char_step;
    logic flush_step;
    logic prep;
    logic eval_step;
    logic arith_exec;
    logic mul_fin;
    logic div_fin;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             item_last;
    logic             pop_cond;
    logic             op_empty;
    logic             eval_end;
    logic             tok_arith_go;
    logic             tok_mul;
    logic             tok_div;
    logic             div_zero;
    logic             div_done;
    logic             out_free;
  } dp_stat_t;

  function automatic logic is_letter(input logic [SYM_W-1:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic is_arith(input logic [SYM_W-1:0] c);
    return (c == CH_MUL) || (c == CH_DIV) || (c == CH_ADD) || (c == CH_SUB);
  endfunction

  // Clamp a wide signed value to the value range
  function automatic val_t sat_val(input logic signed [2*VAL_W-1:0] x);
    val_t r;
    if (x > WIDE_MAX) r = WIDE_MAX[VAL_W-1:0];
    else if (x < WIDE_MIN) r = WIDE_MIN[VAL_W-1:0];
    else r = x[VAL_W-1:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/iee_div.sv -----
// Sequential restoring divider: saturated (a * 2^FRAC_BITS) / b, truncated toward zero.
module iee_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  iee_pkg::val_t a,
  input  iee_pkg::val_t b,
  output logic          done,
  output iee_pkg::val_t q
);

  localparam int DW = iee_pkg::DIV_W;
  localparam int VW = iee_pkg::VAL_W;
  localparam logic [DW-1:0] POS_LIM = DW'({1'b0, {(VW-1){1'b1}}});
  localparam logic [DW-1:0] NEG_LIM = POS_LIM + 1'b1;

  logic                          busy_r;
  logic                          done_r;
  logic                          neg_r;
  logic [iee_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [DW-1:0]                 dvd_r;
  logic [DW-1:0]                 quo_r;
  logic [VW:0]                   rem_r;
  logic [VW-1:0]                 dsr_r;
  iee_pkg::val_t                 q_r;

  logic [VW-1:0] a_mag;
  logic [VW-1:0] b_mag;
  logic [VW:0]   rem_sh;
  logic          fits;

  assign a_mag  = a[VW-1] ? VW'(-a) : VW'(a);
  assign b_mag  = b[VW-1] ? VW'(-b) : VW'(b);
  assign rem_sh = {rem_r[VW-1:0], dvd_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  // Iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iee_pkg::DIV_CNT_W'(DW);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle, then sign and clamp
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= DW'(a_mag) << iee_pkg::FRAC_BITS;
      dsr_r <= b_mag;
      quo_r <= '0;
      rem_r <= '0;
      neg_r <= a[VW-1] ^ b[VW-1];
    end else if (busy_r && cnt_r != '0) begin
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
    end else if (busy_r) begin
      if (neg_r) q_r <= (quo_r > NEG_LIM) ? NEG_LIM[VW-1:0] : VW'(-quo_r[VW-1:0]);
      else       q_r <= (quo_r > POS_LIM) ? POS_LIM[VW-1:0] : quo_r[VW-1:0];
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- hw/rtl/iee_ctrl.sv -----
// Controller state machine: sequences char handling, line flush, postfix evaluation, direct writes, reads and output.
module iee_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  iee_pkg::dp_stat_t stat,
  output iee_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CHAR   = 4'd2;
  localparam logic [3:0] S_FLUSH  = 4'd3;
  localparam logic [3:0] S_PREP   = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_ARITH  = 4'd6;
  localparam logic [3:0] S_MULFIN = 4'd7;
  localparam logic [3:0] S_DIVW   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.item_cmd)
          iee_pkg::CMD_CHAR:  state_nxt = S_CHAR;
          iee_pkg::CMD_WRITE: begin
            cmd.do_direct = 1'b1;
            state_nxt     = S_IDLE;
          end
          iee_pkg::CMD_READ: begin
            cmd.do_read = 1'b1;
            state_nxt   = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHAR: begin
        cmd.char_step = 1'b1;
        if (!stat.pop_cond) state_nxt = stat.item_last ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        if (stat.op_empty) state_nxt = S_PREP;
        else cmd.flush_step = 1'b1;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat.eval_end) state_nxt = S_FINISH;
        else if (stat.tok_arith_go) state_nxt = S_ARITH;
        else cmd.eval_step = 1'b1;
      end
      S_ARITH: begin
        cmd.arith_exec = 1'b1;
        if (stat.tok_mul) state_nxt = S_MULFIN;
        else if (stat.tok_div && !stat.div_zero) state_nxt = S_DIVW;
        else state_nxt = S_EVAL;
      end
      S_MULFIN: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.div_fin = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/iee_dp.sv -----
// Datapath: item registers, variable file, operator stack, postfix buffer, value stack, output.
module iee_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [iee_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [iee_pkg::CMD_W-1:0]          in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [iee_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [iee_pkg::STAT_W-1:0]         out_tuser,
  input  iee_pkg::dp_cmd_t                   cmd,
  output iee_pkg::dp_stat_t                  stat
);

  localparam int PW = iee_pkg::PTR_W;
  localparam int CW = iee_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(iee_pkg::LINE_CHARS);

  // Item registers
  logic [iee_pkg::CMD_W-1:0] it_cmd_r;
  logic [iee_pkg::SYM_W-1:0] it_sym_r;
  logic                      it_last_r;
  logic [iee_pkg::VAR_W-1:0] it_idx_r;
  iee_pkg::val_t             it_wval_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_cmd_r  <= in_tuser;
      it_sym_r  <= in_tdata[iee_pkg::SYM_W-1:0];
      it_last_r <= in_tlast;
      it_idx_r  <= in_tdata[iee_pkg::IDX_LSB +: iee_pkg::VAR_W];
      it_wval_r <= in_tdata[iee_pkg::WVAL_LSB +: iee_pkg::VAL_W];
    end
  end

  // Stores
  iee_pkg::val_t             var_r [iee_pkg::NUM_VARS];
  logic [iee_pkg::SYM_W-1:0] op_r  [iee_pkg::LINE_CHARS];
  logic [iee_pkg::SYM_W-1:0] pf_r  [iee_pkg::LINE_CHARS];
  iee_pkg::val_t             vs_mem [iee_pkg::LINE_CHARS];

  logic [CW-1:0] op_cnt_r, op_cnt_nxt;
  logic [CW-1:0] pf_cnt_r, pf_cnt_nxt;
  logic          mal_r, mal_nxt;
  logic          ovf_r, ovf_nxt;

  // Evaluation state
  logic [CW-1:0]              ev_i_r, ev_i_nxt;
  logic [CW-1:0]              depth_r, depth_nxt;
  logic [iee_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                       assigned_r, assigned_nxt;
  iee_pkg::val_t              tos_r, tos_nxt;
  iee_pkg::val_t              value_r, value_nxt;
  logic [iee_pkg::VAR_W-1:0]  target_r, target_nxt;
  iee_pkg::val_t              vs_rd_r;
  logic signed [2*iee_pkg::VAL_W-1:0] prod_r;
  logic signed [2*iee_pkg::VAL_W-1:0] prod_w;

  // Output register
  logic                       out_valid_r;
  logic [iee_pkg::VAR_W-1:0]  out_tgt_r;
  iee_pkg::val_t              out_val_r;
  logic [iee_pkg::STAT_W-1:0] out_st_r;

  // Read taps
  logic [iee_pkg::SYM_W-1:0] op_top;
  logic [iee_pkg::SYM_W-1:0] tok;
  logic [iee_pkg::SYM_W-1:0] pf0;
  logic                      pf_ok;
  logic [iee_pkg::VAR_W-1:0] var_raddr;
  iee_pkg::val_t             var_rdata;
  logic                      pop_cond;
  logic                      div_done;
  iee_pkg::val_t             div_q;
  logic                      div_start;

  assign op_top = (op_cnt_r != '0) ? op_r[PW'(op_cnt_r - 1'b1)] : '0;
  assign tok    = pf_r[ev_i_r[PW-1:0]];
  assign pf0    = pf_r[0];
  assign pf_ok  = (pf_cnt_r != '0) && iee_pkg::is_letter(pf0);
  assign prod_w = vs_rd_r * tos_r;

  // Variable read port
  always_comb begin
    if (cmd.prep)           var_raddr = iee_pkg::VAR_W'(pf0 - iee_pkg::CH_A);
    else if (cmd.eval_step) var_raddr = iee_pkg::VAR_W'(tok - iee_pkg::CH_A);
    else                    var_raddr = it_idx_r;
    var_rdata = (var_raddr < iee_pkg::VAR_W'(iee_pkg::NUM_VARS)) ? var_r[var_raddr] : '0;
  end

  // Operator on top of the stack must move to postfix before this char goes on
  always_comb begin
    pop_cond = 1'b0;
    if (it_sym_r == iee_pkg::CH_MUL || it_sym_r == iee_pkg::CH_DIV)
      pop_cond = (op_top == iee_pkg::CH_MUL) || (op_top == iee_pkg::CH_DIV);
    else if (it_sym_r == iee_pkg::CH_ADD || it_sym_r == iee_pkg::CH_SUB ||
             it_sym_r == iee_pkg::CH_EQ)
      pop_cond = iee_pkg::is_arith(op_top);
    else if (it_sym_r == iee_pkg::CH_RP)
      pop_cond = (op_cnt_r != '0) && (op_top != iee_pkg::CH_LP);
  end

  // Shunting-yard line state
  logic                      do_move, do_opush, do_ppush;
  logic                      pf_we, op_we;
  logic [iee_pkg::SYM_W-1:0] pf_wdata;

  always_comb begin
    op_cnt_nxt = op_cnt_r;
    pf_cnt_nxt = pf_cnt_r;
    mal_nxt    = mal_r;
    ovf_nxt    = ovf_r;
    do_move    = 1'b0;
    do_opush   = 1'b0;
    do_ppush   = 1'b0;
    pf_we      = 1'b0;
    op_we      = 1'b0;
    pf_wdata   = op_top;
    if (cmd.char_step) begin
      if (pop_cond) begin
        do_move = 1'b1;
      end else begin
        case (it_sym_r) inside
          iee_pkg::CH_SPACE: begin
          end
          iee_pkg::CH_MUL, iee_pkg::CH_DIV, iee_pkg::CH_ADD, iee_pkg::CH_SUB,
          iee_pkg::CH_EQ, iee_pkg::CH_LP: do_opush = 1'b1;
          iee_pkg::CH_RP: begin
            if (op_cnt_r == '0) mal_nxt = 1'b1;
            else op_cnt_nxt = op_cnt_r - 1'b1;
          end
          [iee_pkg::CH_A:iee_pkg::CH_Z]: do_ppush = 1'b1;
          default: mal_nxt = 1'b1;
        endcase
      end
    end else if (cmd.flush_step) begin
      if (op_top == iee_pkg::CH_LP) begin
        op_cnt_nxt = op_cnt_r - 1'b1;
        mal_nxt    = 1'b1;
      end else begin
        do_move = 1'b1;
      end
    end else if (cmd.prep) begin
      mal_nxt = mal_r | !pf_ok;
    end else if (cmd.finish) begin
      op_cnt_nxt = '0;
      pf_cnt_nxt = '0;
      mal_nxt    = 1'b0;
      ovf_nxt    = 1'b0;
    end
    // postfix push of either the stack top or the current letter
    if (do_move) op_cnt_nxt = op_cnt_r - 1'b1;
    if (do_ppush) pf_wdata = it_sym_r;
    if (do_move || do_ppush) begin
      if (pf_cnt_r >= FULL) begin
        ovf_nxt = 1'b1;
      end else begin
        pf_we      = 1'b1;
        pf_cnt_nxt = pf_cnt_r + 1'b1;
      end
    end
    if (do_opush) begin
      if (op_cnt_r >= FULL) begin
        ovf_nxt = 1'b1;
      end else begin
        op_we      = 1'b1;
        op_cnt_nxt = op_cnt_r + 1'b1;
      end
    end
  end

  // Postfix evaluation
  logic                       vs_we;
  logic [iee_pkg::STAT_W-1:0] fin_status;

  assign fin_status = (status_r == iee_pkg::ST_OK && !assigned_r) ?
                      iee_pkg::ST_MALFORMED : status_r;

  always_comb begin
    ev_i_nxt     = ev_i_r;
    depth_nxt    = depth_r;
    status_nxt   = status_r;
    assigned_nxt = assigned_r;
    tos_nxt      = tos_r;
    value_nxt    = value_r;
    target_nxt   = target_r;
    vs_we        = 1'b0;
    if (cmd.prep) begin
      target_nxt   = pf_ok ? var_raddr : '0;
      value_nxt    = pf_ok ? var_rdata : '0;
      ev_i_nxt     = CW'(1);
      depth_nxt    = '0;
      assigned_nxt = 1'b0;
      if (ovf_r) status_nxt = iee_pkg::ST_OVERFLOW;
      else if (mal_r || !pf_ok) status_nxt = iee_pkg::ST_MALFORMED;
      else status_nxt = iee_pkg::ST_OK;
    end else if (cmd.eval_step) begin
      ev_i_nxt = ev_i_r + 1'b1;
      if (iee_pkg::is_letter(tok)) begin
        if (depth_r >= FULL) begin
          status_nxt = iee_pkg::ST_OVERFLOW;
        end else begin
          vs_we     = (depth_r != '0);
          tos_nxt   = var_rdata;
          depth_nxt = depth_r + 1'b1;
        end
      end else if (tok == iee_pkg::CH_EQ) begin
        if (depth_r != CW'(1) || ev_i_r != pf_cnt_r - 1'b1) begin
          status_nxt = iee_pkg::ST_MALFORMED;
        end else begin
          value_nxt    = tos_r;
          assigned_nxt = 1'b1;
        end
      end else begin
        status_nxt = iee_pkg::ST_MALFORMED;
      end
    end else if (cmd.arith_exec) begin
      if (tok == iee_pkg::CH_ADD || tok == iee_pkg::CH_SUB) begin
        tos_nxt   = iee_pkg::sat_val((tok == iee_pkg::CH_ADD) ?
                      (2*iee_pkg::VAL_W)'(vs_rd_r) + (2*iee_pkg::VAL_W)'(tos_r) :
                      (2*iee_pkg::VAL_W)'(vs_rd_r) - (2*iee_pkg::VAL_W)'(tos_r));
        depth_nxt = depth_r - 1'b1;
        ev_i_nxt  = ev_i_r + 1'b1;
      end else if (tok == iee_pkg::CH_DIV && tos_r == '0) begin
        status_nxt = iee_pkg::ST_DIV0;
      end
    end else if (cmd.mul_fin) begin
      tos_nxt   = iee_pkg::sat_val(prod_r >>> iee_pkg::FRAC_BITS);
      depth_nxt = depth_r - 1'b1;
      ev_i_nxt  = ev_i_r + 1'b1;
    end else if (cmd.div_fin) begin
      tos_nxt   = div_q;
      depth_nxt = depth_r - 1'b1;
      ev_i_nxt  = ev_i_r + 1'b1;
    end else if (cmd.finish) begin
      status_nxt = fin_status;
    end else if (cmd.do_read) begin
      target_nxt = it_idx_r;
      value_nxt  = var_rdata;
      status_nxt = (it_idx_r < iee_pkg::VAR_W'(iee_pkg::NUM_VARS)) ?
                   iee_pkg::ST_OK : iee_pkg::ST_MALFORMED;
    end
  end

  assign div_start = cmd.arith_exec && (tok == iee_pkg::CH_DIV) && (tos_r != '0);

  iee_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (vs_rd_r),
    .b     (tos_r),
    .done  (div_done),
    .q     (div_q)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cnt_r    <= '0;
      pf_cnt_r    <= '0;
      mal_r       <= 1'b0;
      ovf_r       <= 1'b0;
      ev_i_r      <= '0;
      depth_r     <= '0;
      status_r    <= iee_pkg::ST_OK;
      assigned_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      op_cnt_r   <= op_cnt_nxt;
      pf_cnt_r   <= pf_cnt_nxt;
      mal_r      <= mal_nxt;
      ovf_r      <= ovf_nxt;
      ev_i_r     <= ev_i_nxt;
      depth_r    <= depth_nxt;
      status_r   <= status_nxt;
      assigned_r <= assigned_nxt;
      if (cmd.load_out)    out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Variable file, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iee_pkg::NUM_VARS; i++) var_r[i] <= '0;
    end else if (cmd.do_direct && it_idx_r < iee_pkg::VAR_W'(iee_pkg::NUM_VARS)) begin
      var_r[it_idx_r] <= it_wval_r;
    end else if (cmd.finish && fin_status == iee_pkg::ST_OK) begin
      var_r[target_r] <= value_r;
    end
  end

  // Payload registers and stacks
  always_ff @(posedge clk) begin
    tos_r    <= tos_nxt;
    value_r  <= value_nxt;
    target_r <= target_nxt;
    if (cmd.arith_exec) prod_r <= prod_w;
    if (pf_we) pf_r[pf_cnt_r[PW-1:0]] <= pf_wdata;
    if (op_we) op_r[op_cnt_r[PW-1:0]] <= it_sym_r;
    if (cmd.load_out) begin
      out_tgt_r <= target_r;
      out_val_r <= value_r;
      out_st_r  <= status_r;
    end
  end

  // Value stack below the top entry: one write, one registered read
  always_ff @(posedge clk) begin
    if (vs_we) vs_mem[PW'(depth_r - 1'b1)] <= tos_r;
    vs_rd_r <= vs_mem[PW'(depth_r - CW'(2))];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(iee_pkg::OUT_TDATA_W - iee_pkg::OUT_RAW_W){1'b0}}, out_val_r, out_tgt_r};
  assign out_tuser  = out_st_r;

  always_comb begin
    stat              = '0;
    stat.item_cmd     = it_cmd_r;
    stat.item_last    = it_last_r;
    stat.pop_cond     = pop_cond;
    stat.op_empty     = (op_cnt_r == '0);
    stat.eval_end     = (status_r != iee_pkg::ST_OK) || (ev_i_r >= pf_cnt_r);
    stat.tok_arith_go = iee_pkg::is_arith(tok) && (depth_r >= CW'(2));
    stat.tok_mul      = (tok == iee_pkg::CH_MUL);
    stat.tok_div      = (tok == iee_pkg::CH_DIV);
    stat.div_zero     = (tos_r == '0);
    stat.div_done     = div_done;
    stat.out_free     = !out_valid_r || out_tready;
  end

endmodule

// ----- hw/rtl/infix_expression_evaluator_unit.sv -----
// Top level of the infix expression evaluator: controller, datapath and checks.
//
// Input channel in_*: one word per item. in_tuser is the command (expression
// char, direct variable write, variable read), in_tlast marks the final char
// of an assignment line "V=expr". Output channel out_*: one word per line end
// and per read, carrying the target variable index, its Q16.16 value and a status.
// Items are handled one at a time; in_tready is high only while idle.
// For an expression char, each operator that must leave the stack moves to
// postfix first. A line end moves every operator left on the stack, sets up,
// steps over each letter or '=', runs each add, subtract, multiply and divide
// (the divider retires one quotient bit per cycle over 48 bits), then detects
// the end, finishes and loads the output register.
// After reset all 26 variables read as zero and the line state is empty.
// A finished result sits in the output register while the next item is taken;
// a second result waits in the datapath, with the controller holding, until the receiver drains the first,
// so a stalled receiver stalls input only once a second result is ready.
module infix_expression_evaluator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [iee_pkg::IN_TDATA_W-1:0]   in_tdata,   // symbol, var_index, write_value
  input  logic [iee_pkg::CMD_W-1:0]        in_tuser,   // cmd
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [iee_pkg::OUT_TDATA_W-1:0]  out_tdata,  // target_index, result_value
  output logic [iee_pkg::STAT_W-1:0]       out_tuser   // status
);

  iee_pkg::dp_cmd_t  cmd;
  iee_pkg::dp_stat_t stat;

  iee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iee_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Checks
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after an accept");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a busy cycle");

endmodule
